FILE: rtl/core/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/rv64_pkg.sv
`timescale 1ns / 1ps
package rv64_pkg;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMMW = 7'h1b;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPW    = 7'h3b;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [11:0] CSR_MEPC    = 12'h341;
  localparam logic [11:0] CSR_MCAUSE  = 12'h342;
  localparam logic [11:0] CSR_MSTATUS = 12'h300;
  localparam logic [11:0] CSR_MTVEC   = 12'h305;
  localparam logic [31:0] IW_ECALL  = 32'h00000073;
  localparam logic [31:0] IW_EBREAK = 32'h00100073;
  localparam logic [31:0] IW_MRET   = 32'h30200073;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HALT  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_ALIGN = 2'd3;
  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic        is_rem;
    logic [63:0] a;
    logic [63:0] b;
  } div_req_t;
endpackage

FILE: rtl/core/rv64_ram.sv
`timescale 1ns / 1ps
module rv64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/rv64_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle on magnitudes.
module rv64_div
  import rv64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] result
);
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic        negq_r, negq_nxt, negr_r, negr_nxt, rem_r, rem_nxt;
  logic        zero_r, zero_nxt;
  logic [63:0] a0_r, a0_nxt;
  logic        done_r, done_nxt;
  logic [65:0] trial;
  logic [64:0] shr;
  logic        na, nb;
  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; q_nxt = q_r; r_nxt = r_r; d_nxt = d_r;
    negq_nxt = negq_r; negr_nxt = negr_r; rem_nxt = rem_r; zero_nxt = zero_r;
    a0_nxt = a0_r; done_nxt = 1'b0;
    na = req.is_signed & req.a[63];
    nb = req.is_signed & req.b[63];
    shr = {r_r, q_r[63]};
    trial = {1'b0, shr} - {2'b00, d_r};
    if (req.start) begin
      busy_nxt = 1'b1; cnt_nxt = 7'd0;
      q_nxt = na ? (64'd0 - req.a) : req.a;
      d_nxt = nb ? (64'd0 - req.b) : req.b;
      r_nxt = '0;
      negq_nxt = na ^ nb; negr_nxt = na; rem_nxt = req.is_rem;
      zero_nxt = (req.b == 64'd0); a0_nxt = req.a;
    end else if (busy_r) begin
      if (!trial[65]) begin
        r_nxt = trial[63:0]; q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = shr[63:0]; q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; r_r <= r_nxt; d_r <= d_nxt; negq_r <= negq_nxt;
    negr_r <= negr_nxt; rem_r <= rem_nxt; zero_r <= zero_nxt; a0_r <= a0_nxt;
  end
  assign done = done_r;
  always_comb begin
    if (zero_r) begin
      result = rem_r ? a0_r : '1;
    end else if (rem_r) begin
      result = negr_r ? (64'd0 - r_r) : r_r;
    end else begin
      result = negq_r ? (64'd0 - q_r) : q_r;
    end
  end
endmodule

FILE: rtl/core/rv64im_instruction_execute.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// RV64IM single-issue executor.
// Input beat: in_instr_word, the instruction at the stored PC (valid/ready).
// Output beat: next PC, destination write, operands, immediate and status.
// One instruction is in flight at a time. Register file and data memory are
// synchronous RAMs: S_RS1 reads rs1, S_RS2 reads rs2, S_MEM reads the data
// word and a0, S_EXE executes and writes back. Mul stays in S_EXE for three
// 32x32 partial products; div/rem wait there for the bit-serial divider.
// The output register holds a beat until out_ready; the next instruction is
// accepted only after the output beat leaves and the FSM has passed S_WAIT
// back to S_IDLE. A stalled receiver stalls the input.
// Reset (rst_n low, synchronous): PC = 0x80000000, CSRs zero. The register
// file is cleared by a pass over all 32 entries after reset during which
// in_ready stays low. A cfg_we write of cfg_wdata loads the PC; the user must
// write it only while nothing is in flight, which the block does not enforce.
module rv64im_instruction_execute
  import rv64_pkg::*;
#(
  parameter int DMEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_next_pc,
  output logic [4:0]  out_dest_index,
  output logic [63:0] out_dest_value,
  output logic        out_dest_written,
  output logic [1:0]  out_status,
  output logic [63:0] out_halt_code,
  output logic [63:0] out_first_operand,
  output logic [63:0] out_second_operand,
  output logic [63:0] out_immediate,
  output logic [63:0] out_current_pc
);
  localparam int DAW = $clog2(DMEM_WORDS);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RS1 = 3'd2,
                         S_RS2 = 3'd3, S_MEM = 3'd4, S_EXE = 3'd5,
                         S_WAIT = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [4:0]  clr_r;
  logic [63:0] pc_r, mepc_r, mcause_r, mstatus_r, mtvec_r;
  logic [31:0] iw_r;
  logic [63:0] a_r, b_r, a0v_r, mrd_r, mul_r;
  logic [1:0]  mstep_r;
  logic        ov_r;

  logic        rf_we;
  logic [4:0]  rf_wa, rf_ra;
  logic [63:0] rf_wd, rf_rd;
  logic        dm_we;
  logic [DAW-1:0] dm_wa, dm_ra;
  logic [63:0] dm_wd, dm_rd;
  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dres;

  rv64_ram #(.WIDTH(64), .DEPTH(32)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(rf_ra), .rdata(rf_rd));
  rv64_ram #(.WIDTH(64), .DEPTH(DMEM_WORDS)) u_dm (
    .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd), .raddr(dm_ra), .rdata(dm_rd));
  rv64_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .result(dres));

  logic [6:0] opc;
  logic [4:0] rd, rs1, rs2;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [63:0] iI, iS, iB, iU, iJ;
  assign opc = iw_r[6:0];
  assign rd  = iw_r[11:7];
  assign f3  = iw_r[14:12];
  assign rs1 = iw_r[19:15];
  assign rs2 = iw_r[24:20];
  assign f7  = iw_r[31:25];
  assign iI = {{52{iw_r[31]}}, iw_r[31:20]};
  assign iS = {{52{iw_r[31]}}, iw_r[31:25], iw_r[11:7]};
  assign iB = {{51{iw_r[31]}}, iw_r[31], iw_r[7], iw_r[30:25], iw_r[11:8], 1'b0};
  assign iU = {{32{iw_r[31]}}, iw_r[31:12], 12'd0};
  assign iJ = {{43{iw_r[31]}}, iw_r[31], iw_r[19:12], iw_r[20], iw_r[30:21], 1'b0};

  // address path
  logic [63:0] maddr;
  logic [3:0]  msize;
  logic        mis;
  assign maddr = a_r + ((opc == OPC_STORE) ? iS : iI);
  assign msize = 4'd1 << f3[1:0];
  assign mis = ({1'b0, maddr[2:0]} + msize) > 4'd8;

  logic is_div, is_mul;
  assign is_div = ((opc == OPC_OP) || (opc == OPC_OPW)) && (f7 == 7'd1) && f3[2];
  assign is_mul = ((opc == OPC_OP) || (opc == OPC_OPW)) && (f7 == 7'd1) && (f3 == 3'd0);

  logic [63:0] da, db;
  always_comb begin
    if (opc == OPC_OPW) begin
      da = f3[0] ? {32'd0, a_r[31:0]} : {{32{a_r[31]}}, a_r[31:0]};
      db = f3[0] ? {32'd0, b_r[31:0]} : {{32{b_r[31]}}, b_r[31:0]};
    end else begin
      da = a_r; db = b_r;
    end
    dreq.start = (st_r == S_MEM) && is_div;
    dreq.is_signed = !f3[0];
    dreq.is_rem = f3[1];
    dreq.a = da;
    dreq.b = db;
  end

  // low 64 bits of the product from three 32x32 partial products
  logic [31:0] mx, my;
  logic [63:0] mprod;
  always_comb begin
    mx = a_r[31:0]; my = b_r[31:0];
    if (st_r == S_EXE) begin
      if (mstep_r == 2'd0) my = b_r[63:32];
      else mx = a_r[63:32];
    end
    mprod = {32'd0, mx} * {32'd0, my};
  end

  // execute
  logic [63:0] res, npc, op1, op2, imm, halt, csr_old, csr_new, lw, lsh;
  logic [1:0]  status;
  logic        wr, bad, take, csr_w;
  logic [5:0]  shamt;
  logic [31:0] w32, sraw;
  logic        slt;
  always_comb begin
    res = '0; npc = pc_r + 64'd4; op1 = '0; op2 = '0; imm = '0; halt = '0;
    status = ST_OK; wr = 1'b0; bad = 1'b0; take = 1'b0; csr_w = 1'b0;
    csr_new = '0; w32 = '0; sraw = '0; slt = 1'b0; shamt = '0;
    lsh = dm_rd >> {maddr[2:0], 3'd0};
    lw = lsh;
    case (msize)
      4'd1: lw = f3[2] ? {56'd0, lsh[7:0]} : {{56{lsh[7]}}, lsh[7:0]};
      4'd2: lw = f3[2] ? {48'd0, lsh[15:0]} : {{48{lsh[15]}}, lsh[15:0]};
      4'd4: lw = f3[2] ? {32'd0, lsh[31:0]} : {{32{lsh[31]}}, lsh[31:0]};
      default: lw = lsh;
    endcase
    case (iw_r[31:20])
      CSR_MEPC:    csr_old = mepc_r;
      CSR_MCAUSE:  csr_old = mcause_r;
      CSR_MSTATUS: csr_old = mstatus_r;
      CSR_MTVEC:   csr_old = mtvec_r;
      default:     csr_old = '0;
    endcase
    case (opc)
      OPC_LUI: begin imm = iU; res = iU; wr = 1'b1; end
      OPC_AUIPC: begin imm = iU; res = pc_r + iU; wr = 1'b1; end
      OPC_JAL: begin imm = iJ; npc = pc_r + iJ; res = pc_r + 64'd4; wr = 1'b1; end
      OPC_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        op1 = a_r; imm = iI; res = pc_r + 64'd4; wr = 1'b1;
        npc = (a_r + iI) & ~64'd1;
      end
      OPC_BRANCH: begin
        op1 = a_r; op2 = b_r; imm = iB;
        slt = $signed(a_r) < $signed(b_r);
        case (f3)
          3'd0: take = a_r == b_r;
          3'd1: take = a_r != b_r;
          3'd4: take = slt;
          3'd5: take = !slt;
          3'd6: take = a_r < b_r;
          3'd7: take = a_r >= b_r;
          default: bad = 1'b1;
        endcase
        if (take) npc = pc_r + iB;
      end
      OPC_LOAD, OPC_STORE: begin
        if ((opc == OPC_LOAD && f3 == 3'd7) || (opc == OPC_STORE && f3[2])) bad = 1'b1;
        op1 = a_r;
        if (opc == OPC_STORE) begin op2 = b_r; imm = iS; end else imm = iI;
        if (mis) status = ST_ALIGN;
        else if (opc == OPC_LOAD) begin res = lw; wr = 1'b1; end
      end
      OPC_OPIMM: begin
        op1 = a_r; imm = iI; wr = 1'b1; shamt = iw_r[25:20];
        case (f3)
          3'd0: res = a_r + iI;
          3'd2: res = {63'd0, $signed(a_r) < $signed(iI)};
          3'd3: res = {63'd0, a_r < iI};
          3'd4: res = a_r ^ iI;
          3'd6: res = a_r | iI;
          3'd7: res = a_r & iI;
          3'd1: begin
            if (iw_r[31:26] != 6'd0) bad = 1'b1;
            res = a_r << shamt;
          end
          default: begin
            if (iw_r[31:26] == 6'd0) res = a_r >> shamt;
            else if (iw_r[31:26] == 6'h10) res = $unsigned($signed(a_r) >>> shamt);
            else bad = 1'b1;
          end
        endcase
      end
      OPC_OPIMMW, OPC_OPW: begin
        op1 = a_r; wr = 1'b1;
        if (opc == OPC_OPW) begin
          op2 = b_r; shamt = {1'b0, b_r[4:0]};
        end else begin
          imm = iI; shamt = {1'b0, iw_r[24:20]};
        end
        sraw = $unsigned($signed(a_r[31:0]) >>> shamt[4:0]);
        if (f3 == 3'd0 && (opc == OPC_OPIMMW || f7 == 7'd0)) w32 = a_r[31:0] +
          ((opc == OPC_OPW) ? b_r[31:0] : iI[31:0]);
        else if (opc == OPC_OPW && f7 == 7'h20 && f3 == 3'd0) w32 = a_r[31:0] - b_r[31:0];
        else if (f7 == 7'd0 && f3 == 3'd1) w32 = a_r[31:0] << shamt[4:0];
        else if (f7 == 7'd0 && f3 == 3'd5) w32 = a_r[31:0] >> shamt[4:0];
        else if (f7 == 7'h20 && f3 == 3'd5) w32 = sraw;
        else if (opc == OPC_OPW && is_mul) w32 = mul_r[31:0];
        else if (opc == OPC_OPW && is_div) w32 = dres[31:0];
        else bad = 1'b1;
        res = {{32{w32[31]}}, w32};
      end
      OPC_OP: begin
        op1 = a_r; op2 = b_r; wr = 1'b1; shamt = b_r[5:0];
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: res = a_r + b_r;
            3'd1: res = a_r << shamt;
            3'd2: res = {63'd0, $signed(a_r) < $signed(b_r)};
            3'd3: res = {63'd0, a_r < b_r};
            3'd4: res = a_r ^ b_r;
            3'd5: res = a_r >> shamt;
            3'd6: res = a_r | b_r;
            default: res = a_r & b_r;
          endcase
        end else if (f7 == 7'h20 && f3 == 3'd0) res = a_r - b_r;
        else if (f7 == 7'h20 && f3 == 3'd5) res = $unsigned($signed(a_r) >>> shamt);
        else if (is_mul) res = mul_r;
        else if (is_div) res = dres;
        else bad = 1'b1;
      end
      OPC_SYSTEM: begin
        if (f3 inside {3'd1, 3'd2, 3'd3}) begin
          op1 = a_r; imm = {52'd0, iw_r[31:20]}; res = csr_old; wr = 1'b1; csr_w = 1'b1;
          case (f3[1:0])
            2'd1: csr_new = a_r;
            2'd2: csr_new = csr_old | a_r;
            default: csr_new = csr_old & ~a_r;
          endcase
        end else if (iw_r == IW_ECALL) npc = mtvec_r;
        else if (iw_r == IW_EBREAK) begin status = ST_HALT; halt = a0v_r; end
        else if (iw_r == IW_MRET) npc = mepc_r;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      op1 = '0; op2 = '0; imm = '0; wr = 1'b0; npc = pc_r + 64'd4; status = ST_BAD;
      csr_w = 1'b0;
    end
    if (status == ST_ALIGN) wr = 1'b0;
    wr = wr && (rd != 5'd0);
  end

  logic exe_fire, st_ok;
  assign exe_fire = (st_r == S_EXE) && (!is_div || ddone) && (!is_mul || mstep_r == 2'd2);
  assign st_ok = exe_fire && !bad && (opc == OPC_STORE) && !mis;

  logic [63:0] smask, sdata;
  always_comb begin
    case (msize)
      4'd1: smask = 64'hff;
      4'd2: smask = 64'hffff;
      4'd4: smask = 64'hffff_ffff;
      default: smask = '1;
    endcase
    smask = smask << {maddr[2:0], 3'd0};
    sdata = b_r << {maddr[2:0], 3'd0};
    dm_we = st_ok;
    dm_wa = maddr[DAW+2:3];
    dm_wd = (dm_rd & ~smask) | (sdata & smask);
    dm_ra = maddr[DAW+2:3];
  end

  // register file port control
  always_comb begin
    rf_we = 1'b0; rf_wa = rd; rf_wd = res; rf_ra = 5'd10;
    if (st_r == S_CLR) begin
      rf_we = 1'b1; rf_wa = clr_r; rf_wd = '0;
    end else if (exe_fire && wr) begin
      rf_we = 1'b1;
    end
    case (st_r)
      S_IDLE: rf_ra = in_instr_word[19:15];
      S_RS1:  rf_ra = rs2;
      default: rf_ra = 5'd10;
    endcase
  end

  assign in_ready = (st_r == S_IDLE) && !ov_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLR: if (clr_r == 5'd31) st_nxt = S_IDLE;
      S_IDLE: if (in_valid && in_ready) st_nxt = S_RS1;
      S_RS1: st_nxt = S_RS2;
      S_RS2: st_nxt = S_MEM;
      S_MEM: st_nxt = S_EXE;
      S_EXE: if (exe_fire) st_nxt = S_WAIT;
      S_WAIT: if (!ov_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; ov_r <= 1'b0;
      pc_r <= 64'h8000_0000;
      mepc_r <= '0; mcause_r <= '0; mstatus_r <= '0; mtvec_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_CLR) clr_r <= clr_r + 5'd1;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (exe_fire) begin
        ov_r <= 1'b1;
        pc_r <= npc;
        if (csr_w) begin
          case (iw_r[31:20])
            CSR_MEPC:    mepc_r <= csr_new;
            CSR_MCAUSE:  mcause_r <= csr_new;
            CSR_MSTATUS: mstatus_r <= csr_new;
            CSR_MTVEC:   mtvec_r <= csr_new;
            default: ;
          endcase
        end
        if (!bad && iw_r == IW_ECALL) begin
          mepc_r <= pc_r; mcause_r <= 64'd11;
        end
      end
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
    end
    if (in_valid && in_ready) iw_r <= in_instr_word;
    if (st_r == S_RS1) a_r <= rf_rd;
    if (st_r == S_RS2) b_r <= rf_rd;
    if (st_r == S_MEM) a0v_r <= rf_rd;
    if (st_r == S_MEM) begin
      mul_r <= mprod; mstep_r <= 2'd0;
    end else if (st_r == S_EXE && is_mul && mstep_r != 2'd2) begin
      mul_r <= mul_r + {mprod[31:0], 32'd0}; mstep_r <= mstep_r + 2'd1;
    end
    if (exe_fire) begin
      out_next_pc <= npc; out_dest_index <= rd; out_dest_value <= wr ? res : '0;
      out_dest_written <= wr; out_status <= status; out_halt_code <= halt;
      out_first_operand <= op1; out_second_operand <= op2; out_immediate <= imm;
      out_current_pc <= pc_r;
    end
  end
  assign out_valid = ov_r;

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, in_valid && in_ready, !out_valid)
  `ASSERT_NEXT(a_exe_out, clk, rst_n, exe_fire, out_valid)
  `ASSERT_IMPL(a_x0_never, clk, rst_n, rf_we && st_r != S_CLR, rf_wa != 5'd0)
endmodule
